>>> src/rv64im_instruction_decoder_unit_assert.svh
// ----------------------------------------------------------------------------
// rv64im_instruction_decoder_unit_assert.svh
// Assertion macros shared by the decoder RTL; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef RV64IM_INSTRUCTION_DECODER_UNIT_ASSERT_SVH
`define RV64IM_INSTRUCTION_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RVD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rvd assertion failed");
// next-cycle implication
`define RVD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rvd assertion failed");
`else
`define RVD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RVD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> src/rvd_pkg.sv
// ----------------------------------------------------------------------------
// rvd_pkg
// Types, instruction numbers and lookup tables for the RV64IM decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rvd_pkg;

    typedef logic [31:0] t_word;
    typedef logic [6:0]  t_num;
    typedef logic [4:0]  t_reg;

    typedef enum logic [2:0] {
        FMT_NONE = 3'd0,
        FMT_R    = 3'd1,
        FMT_I    = 3'd2,
        FMT_U    = 3'd3,
        FMT_S    = 3'd4,
        FMT_B    = 3'd5,
        FMT_J    = 3'd6,
        FMT_CSR  = 3'd7
    } t_fmt;

    // major opcodes
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_IMM    = 7'h13;
    localparam logic [6:0] OPC_IMM_W  = 7'h1B;
    localparam logic [6:0] OPC_REG    = 7'h33;
    localparam logic [6:0] OPC_REG_W  = 7'h3B;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;
    localparam logic [6:0] OPC_TRAP   = 7'h6B;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [6:0] F7_MUL  = 7'h01;

    localparam t_word WORD_ECALL = 32'h0000_0073;
    localparam t_word WORD_MRET  = 32'h3020_0073;

    // instruction numbers
    localparam t_num N_INVALID = 7'd0;
    localparam t_num N_SRAI    = 7'd2;
    localparam t_num N_SUB     = 7'd11;
    localparam t_num N_SRA     = 7'd14;
    localparam t_num N_MUL     = 7'd18;
    localparam t_num N_SLT     = 7'd26;
    localparam t_num N_SLTU    = 7'd27;
    localparam t_num N_ADDIW   = 7'd28;
    localparam t_num N_SLLIW   = 7'd29;
    localparam t_num N_SRLIW   = 7'd30;
    localparam t_num N_SRAIW   = 7'd31;
    localparam t_num N_ADDW    = 7'd32;
    localparam t_num N_SUBW    = 7'd33;
    localparam t_num N_SLLW    = 7'd34;
    localparam t_num N_SRLW    = 7'd35;
    localparam t_num N_SRAW    = 7'd36;
    localparam t_num N_MULW    = 7'd37;
    localparam t_num N_DIVW    = 7'd38;
    localparam t_num N_SB      = 7'd49;
    localparam t_num N_CSRRW   = 7'd59;
    localparam t_num N_LUI     = 7'd62;
    localparam t_num N_AUIPC   = 7'd63;
    localparam t_num N_JAL     = 7'd64;
    localparam t_num N_JALR    = 7'd65;
    localparam t_num N_ECALL   = 7'd66;
    localparam t_num N_MRET    = 7'd67;
    localparam t_num N_TRAP    = 7'd68;

    // tables indexed by funct3
    localparam t_num OP_IMM_NUM [8] = '{7'd3, 7'd4, 7'd8, 7'd9, 7'd5, 7'd1, 7'd6, 7'd7};
    localparam t_num OP_REG_NUM [8] = '{7'd10, 7'd12, 7'd26, 7'd27, 7'd15, 7'd13,
                                        7'd16, 7'd17};
    localparam t_num LOAD_NUM   [8] = '{7'd42, 7'd44, 7'd46, 7'd48, 7'd43, 7'd45,
                                        7'd47, 7'd0};
    localparam t_num BRANCH_NUM [8] = '{7'd53, 7'd54, 7'd0, 7'd0, 7'd55, 7'd56,
                                        7'd57, 7'd58};

    typedef struct packed {
        logic  valid;
        t_word word;
        t_num  num;
        t_fmt  fmt;
    } t_dec;

endpackage

`default_nettype wire

>>> src/rvd_classify.sv
// ----------------------------------------------------------------------------
// rvd_classify
// Pattern match stage: instruction number and operand format, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rvd_classify (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  wire rvd_pkg::t_word i_word,
    output rvd_pkg::t_dec     o_dec
);
    import rvd_pkg::*;

    logic [6:0] opc;
    logic [2:0] f3;
    logic [6:0] f7;
    logic       b30;
    t_num       num;
    t_fmt       fmt;
    t_dec       r_dec;
    t_dec       n_dec;

    assign opc = i_word[6:0];
    assign f3  = i_word[14:12];
    assign f7  = i_word[31:25];
    assign b30 = i_word[30];

    always_comb begin
        num = N_INVALID;
        fmt = FMT_NONE;
        unique case (opc)
            OPC_LUI: begin
                num = N_LUI;
                fmt = FMT_U;
            end
            OPC_AUIPC: begin
                num = N_AUIPC;
                fmt = FMT_U;
            end
            OPC_LOAD: begin
                num = LOAD_NUM[f3];
                fmt = FMT_I;
            end
            OPC_STORE: begin
                num = f3[2] ? N_INVALID : N_SB + t_num'(f3);
                fmt = FMT_S;
            end
            OPC_IMM: begin
                num = (f3 == 3'd5 && b30) ? N_SRAI : OP_IMM_NUM[f3];
                fmt = FMT_I;
            end
            OPC_IMM_W: begin
                fmt = FMT_I;
                case (f3)
                    3'd0:    num = N_ADDIW;
                    3'd1:    num = N_SLLIW;
                    3'd5:    num = b30 ? N_SRAIW : N_SRLIW;
                    default: num = N_INVALID;
                endcase
            end
            OPC_REG: begin
                fmt = FMT_R;
                if (f7 == F7_BASE) begin
                    num = OP_REG_NUM[f3];
                end else if (f7 == F7_ALT && f3 == 3'd0) begin
                    num = N_SUB;
                end else if (f7 == F7_ALT && f3 == 3'd5) begin
                    num = N_SRA;
                end else if (f7 == F7_MUL) begin
                    num = N_MUL + t_num'(f3);
                end else if (f3 == 3'd2) begin
                    num = N_SLT;
                end else if (f3 == 3'd3) begin
                    num = N_SLTU;
                end
            end
            OPC_REG_W: begin
                fmt = FMT_R;
                if (f7 == F7_BASE) begin
                    case (f3)
                        3'd0:    num = N_ADDW;
                        3'd1:    num = N_SLLW;
                        3'd5:    num = N_SRLW;
                        default: num = N_INVALID;
                    endcase
                end else if (f7 == F7_ALT) begin
                    case (f3)
                        3'd0:    num = N_SUBW;
                        3'd1:    num = N_SLLW;
                        3'd5:    num = N_SRAW;
                        default: num = N_INVALID;
                    endcase
                end else if (f3 == 3'd1) begin
                    num = N_SLLW;
                end else if (f7 == F7_MUL) begin
                    if (f3 == 3'd0) begin
                        num = N_MULW;
                    end else if (f3[2]) begin
                        num = N_DIVW + t_num'(f3[1:0]);
                    end
                end
            end
            OPC_JAL: begin
                num = N_JAL;
                fmt = FMT_J;
            end
            OPC_JALR: begin
                num = N_JALR;
                fmt = FMT_I;
            end
            OPC_BRANCH: begin
                num = BRANCH_NUM[f3];
                fmt = FMT_B;
            end
            OPC_SYSTEM: begin
                if (i_word == WORD_ECALL) begin
                    num = N_ECALL;
                end else if (i_word == WORD_MRET) begin
                    num = N_MRET;
                end else begin
                    fmt = FMT_CSR;
                    num = (f3 >= 3'd1 && f3 <= 3'd3) ? N_CSRRW + t_num'(f3) - 7'd1
                                                     : N_INVALID;
                end
            end
            OPC_TRAP: begin
                num = N_TRAP;
            end
            default: begin
                num = N_INVALID;
            end
        endcase
        if (num == N_INVALID) begin
            fmt = FMT_NONE;
        end
    end

    always_comb begin
        n_dec.valid = i_valid;
        n_dec.word  = i_word;
        n_dec.num   = num;
        n_dec.fmt   = fmt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec.valid <= 1'b0;
        end else begin
            r_dec.valid <= n_dec.valid;
        end
        r_dec.word <= n_dec.word;
        r_dec.num  <= n_dec.num;
        r_dec.fmt  <= n_dec.fmt;
    end

    assign o_dec = r_dec;

endmodule

`default_nettype wire

>>> src/rvd_fields.sv
// ----------------------------------------------------------------------------
// rvd_fields
// Operand stage: register indices, immediate, CSR address, output registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rvd_fields (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire rvd_pkg::t_dec   i_dec,
    output logic                 o_valid,
    output rvd_pkg::t_num        o_instr_number,
    output logic [2:0]           o_operand_format,
    output rvd_pkg::t_reg        o_src1_index,
    output rvd_pkg::t_reg        o_src2_index,
    output rvd_pkg::t_reg        o_dest_index,
    output logic signed [31:0]   o_immediate,
    output logic [11:0]          o_csr_address,
    output logic                 o_dest_discard
);
    import rvd_pkg::*;

    t_word       w;
    t_reg        rd;
    t_reg        rs1;
    t_reg        rs2;
    t_reg        n_s1;
    t_reg        n_s2;
    t_reg        n_d;
    logic [31:0] n_imm;
    logic [11:0] n_csr;
    logic        has_dest;

    logic        r_valid;
    t_num        r_num;
    t_fmt        r_fmt;
    t_reg        r_s1;
    t_reg        r_s2;
    t_reg        r_d;
    logic [31:0] r_imm;
    logic [11:0] r_csr;
    logic        r_discard;

    assign w   = i_dec.word;
    assign rd  = w[11:7];
    assign rs1 = w[19:15];
    assign rs2 = w[24:20];

    always_comb begin
        n_s1     = '0;
        n_s2     = '0;
        n_d      = '0;
        n_imm    = '0;
        n_csr    = '0;
        has_dest = 1'b0;
        unique case (i_dec.fmt)
            FMT_R: begin
                n_s1     = rs1;
                n_s2     = rs2;
                n_d      = rd;
                has_dest = 1'b1;
            end
            FMT_I: begin
                n_s1     = rs1;
                n_d      = rd;
                n_imm    = {{20{w[31]}}, w[31:20]};
                has_dest = 1'b1;
            end
            FMT_U: begin
                n_d      = rd;
                n_imm    = {w[31:12], 12'b0};
                has_dest = 1'b1;
            end
            FMT_S: begin
                n_s1     = rs1;
                n_s2     = rs2;
                n_d      = rs2;
                n_imm    = {{20{w[31]}}, w[31:25], w[11:7]};
                has_dest = 1'b1;
            end
            FMT_B: begin
                n_s1  = rs1;
                n_s2  = rs2;
                n_imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            end
            FMT_J: begin
                n_d      = rd;
                n_imm    = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
                has_dest = 1'b1;
            end
            FMT_CSR: begin
                n_s1     = rs1;
                n_d      = rd;
                n_csr    = w[31:20];
                has_dest = 1'b1;
            end
            default: begin
                has_dest = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_dec.valid;
        end
        r_num     <= i_dec.num;
        r_fmt     <= i_dec.fmt;
        r_s1      <= n_s1;
        r_s2      <= n_s2;
        r_d       <= n_d;
        r_imm     <= n_imm;
        r_csr     <= n_csr;
        r_discard <= has_dest && (n_d == '0);
    end

    assign o_valid          = r_valid;
    assign o_instr_number   = r_num;
    assign o_operand_format = r_fmt;
    assign o_src1_index     = r_s1;
    assign o_src2_index     = r_s2;
    assign o_dest_index     = r_d;
    assign o_immediate      = r_imm;
    assign o_csr_address    = r_csr;
    assign o_dest_discard   = r_discard;

endmodule

`default_nettype wire

>>> src/rv64im_instruction_decoder_unit.sv
// ----------------------------------------------------------------------------
// rv64im_instruction_decoder_unit
// RV64IM instruction decoder, three register stages.
//
// Request channel: drive i_instr_word and pulse start; a request is taken at
// any rising edge with start high and busy low. busy is tied low, so a new
// word may be issued every cycle.
// Result channel: o_valid is high for exactly one cycle per request, with the
// instruction number, operand format, register indices, immediate, CSR
// address and discard flag on the o_ ports during that cycle.
// Each request passes the input register, the pattern match register and the
// operand register, in that order.
// Throughput: one request per cycle; every stage advances each cycle.
// Results come out in request order. The receiver cannot stall, so no stage
// ever holds back.
// Reset (i_rst_n low at a clock edge) clears all stage valid bits; requests
// in flight are dropped and o_valid is low from the next cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rv64im_instruction_decoder_unit_assert.svh"

module rv64im_instruction_decoder_unit (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    input  wire rvd_pkg::t_word  i_instr_word,
    output logic                 busy,
    output logic                 o_valid,
    output rvd_pkg::t_num        o_instr_number,
    output logic [2:0]           o_operand_format,
    output rvd_pkg::t_reg        o_src1_index,
    output rvd_pkg::t_reg        o_src2_index,
    output rvd_pkg::t_reg        o_dest_index,
    output logic signed [31:0]   o_immediate,
    output logic [11:0]          o_csr_address,
    output logic                 o_dest_discard
);
    import rvd_pkg::*;

    logic  r_in_valid;
    t_word r_in_word;
    logic  n_in_valid;
    t_dec  dec;

    assign busy       = 1'b0;
    assign n_in_valid = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
        r_in_word <= i_instr_word;
    end

    rvd_classify u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_word  (r_in_word),
        .o_dec   (dec)
    );

    rvd_fields u_fields (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_dec            (dec),
        .o_valid          (o_valid),
        .o_instr_number   (o_instr_number),
        .o_operand_format (o_operand_format),
        .o_src1_index     (o_src1_index),
        .o_src2_index     (o_src2_index),
        .o_dest_index     (o_dest_index),
        .o_immediate      (o_immediate),
        .o_csr_address    (o_csr_address),
        .o_dest_discard   (o_dest_discard)
    );

    `RVD_ASSERT_NXT(a_stage_follow, i_clk, i_rst_n, dec.valid, o_valid)
    `RVD_ASSERT_IMP(a_invalid_clean, i_clk, i_rst_n, o_valid && o_instr_number == N_INVALID, o_operand_format == FMT_NONE && o_dest_discard == 1'b0 && o_immediate == 32'sd0)
    `RVD_ASSERT_IMP(a_branch_no_dest, i_clk, i_rst_n, o_valid && o_operand_format == FMT_B, o_dest_index == '0 && !o_dest_discard && o_csr_address == '0)
    `RVD_ASSERT_IMP(a_csr_no_imm, i_clk, i_rst_n, o_valid && o_operand_format == FMT_CSR, o_immediate == 32'sd0 && o_src2_index == '0)

endmodule

`default_nettype wire

>>> sim/rv64im_instruction_decoder_unit_checker.sv
// ----------------------------------------------------------------------------
// rv64im_instruction_decoder_unit_checker
// Result checker for the RV64IM decoder. Watches the request and result
// ports, decodes each accepted word on its own and compares every result
// field against the oldest outstanding decode, in request order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rvd_tb_pkg;

    // instruction numbers, in the decoder's numbering order
    typedef enum logic [6:0] {
        I_INVALID, I_SRLI, I_SRAI, I_ADDI, I_SLLI, I_XORI, I_ORI, I_ANDI, I_SLTI, I_SLTIU,
        I_ADD, I_SUB, I_SLL, I_SRL, I_SRA, I_XOR, I_OR, I_AND,
        I_MUL, I_MULH, I_MULHSU, I_MULHU, I_DIV, I_DIVU, I_REM, I_REMU, I_SLT, I_SLTU,
        I_ADDIW, I_SLLIW, I_SRLIW, I_SRAIW,
        I_ADDW, I_SUBW, I_SLLW, I_SRLW, I_SRAW, I_MULW, I_DIVW, I_DIVUW, I_REMW, I_REMUW,
        I_LB, I_LBU, I_LH, I_LHU, I_LW, I_LWU, I_LD,
        I_SB, I_SH, I_SW, I_SD,
        I_BEQ, I_BNE, I_BLT, I_BGE, I_BLTU, I_BGEU,
        I_CSRRW, I_CSRRS, I_CSRRC,
        I_LUI, I_AUIPC, I_JAL, I_JALR, I_ECALL, I_MRET, I_TRAP
    } instr_e;

    // funct3 codes
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SRL  = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

endpackage

module rv64im_instruction_decoder_unit_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_busy,
    input  rvd_pkg::t_word      i_instr_word,
    input  logic                i_valid,
    input  rvd_pkg::t_num       i_instr_number,
    input  logic [2:0]          i_operand_format,
    input  rvd_pkg::t_reg       i_src1_index,
    input  rvd_pkg::t_reg       i_src2_index,
    input  rvd_pkg::t_reg       i_dest_index,
    input  logic signed [31:0]  i_immediate,
    input  logic [11:0]         i_csr_address,
    input  logic                i_dest_discard,
    output int                  o_fail_count,
    output int                  o_pending
);

    import rvd_pkg::*;
    import rvd_tb_pkg::*;

    typedef struct {
        t_num        num;
        t_fmt        fmt;
        t_reg        rs1;
        t_reg        rs2;
        t_reg        rd;
        logic [31:0] imm;
        logic [11:0] csr;
        logic        discard;
    } decode_t;

    localparam instr_e IMM_OPS [8] = '{I_ADDI, I_SLLI, I_SLTI, I_SLTIU,
                                       I_XORI, I_SRLI, I_ORI, I_ANDI};
    localparam instr_e REG_OPS [8] = '{I_ADD, I_SLL, I_SLT, I_SLTU,
                                       I_XOR, I_SRL, I_OR, I_AND};
    localparam instr_e LD_OPS  [8] = '{I_LB, I_LH, I_LW, I_LD,
                                       I_LBU, I_LHU, I_LWU, I_INVALID};
    localparam instr_e BR_OPS  [8] = '{I_BEQ, I_BNE, I_INVALID, I_INVALID,
                                       I_BLT, I_BGE, I_BLTU, I_BGEU};

    decode_t decode_q [$];
    int      fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic t_num reg_op(logic [2:0] f3, logic [6:0] f7);
        if (f7 == F7_BASE) return REG_OPS[f3];
        if (f7 == F7_ALT && f3 == F3_ADD) return I_SUB;
        if (f7 == F7_ALT && f3 == F3_SRL) return I_SRA;
        if (f7 == F7_MUL) return I_MUL + f3;
        if (f3 == F3_SLT) return I_SLT;
        if (f3 == F3_SLTU) return I_SLTU;
        return I_INVALID;
    endfunction

    function automatic t_num reg_w_op(logic [2:0] f3, logic [6:0] f7);
        if (f7 == F7_BASE) begin
            case (f3)
                F3_ADD:  return I_ADDW;
                F3_SLL:  return I_SLLW;
                F3_SRL:  return I_SRLW;
                default: return I_INVALID;
            endcase
        end
        if (f7 == F7_ALT) begin
            case (f3)
                F3_ADD:  return I_SUBW;
                F3_SLL:  return I_SLLW;
                F3_SRL:  return I_SRAW;
                default: return I_INVALID;
            endcase
        end
        if (f3 == F3_SLL) return I_SLLW;
        if (f7 == F7_MUL && f3 == F3_ADD) return I_MULW;
        if (f7 == F7_MUL && f3 >= F3_XOR) return I_DIVW + (f3 - F3_XOR);
        return I_INVALID;
    endfunction

    function automatic decode_t decode_word(t_word w);
        decode_t     r;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic        has_rd;
        f3 = w[14:12];
        f7 = w[31:25];
        r = '{num: I_INVALID, fmt: FMT_NONE, rs1: '0, rs2: '0, rd: '0, imm: '0,
              csr: '0, discard: 1'b0};
        has_rd = 1'b0;
        case (w[6:0])
            OPC_LUI:    begin r.num = I_LUI;   r.fmt = FMT_U; end
            OPC_AUIPC:  begin r.num = I_AUIPC; r.fmt = FMT_U; end
            OPC_LOAD:   begin r.num = LD_OPS[f3]; r.fmt = FMT_I; end
            OPC_STORE:  begin r.num = f3[2] ? I_INVALID : I_SB + f3; r.fmt = FMT_S; end
            OPC_IMM: begin
                r.num = (f3 == F3_SRL && w[30]) ? I_SRAI : IMM_OPS[f3];
                r.fmt = FMT_I;
            end
            OPC_IMM_W: begin
                case (f3)
                    F3_ADD:  r.num = I_ADDIW;
                    F3_SLL:  r.num = I_SLLIW;
                    F3_SRL:  r.num = w[30] ? I_SRAIW : I_SRLIW;
                    default: r.num = I_INVALID;
                endcase
                r.fmt = FMT_I;
            end
            OPC_REG:    begin r.num = reg_op(f3, f7);   r.fmt = FMT_R; end
            OPC_REG_W:  begin r.num = reg_w_op(f3, f7); r.fmt = FMT_R; end
            OPC_JAL:    begin r.num = I_JAL;  r.fmt = FMT_J; end
            OPC_JALR:   begin r.num = I_JALR; r.fmt = FMT_I; end
            OPC_BRANCH: begin r.num = BR_OPS[f3]; r.fmt = FMT_B; end
            OPC_SYSTEM: begin
                if (w == WORD_ECALL) begin
                    r.num = I_ECALL;
                end else if (w == WORD_MRET) begin
                    r.num = I_MRET;
                end else begin
                    r.num = (f3 >= F3_SLL && f3 <= F3_SLTU) ? I_CSRRW + (f3 - F3_SLL)
                                                            : I_INVALID;
                    r.fmt = FMT_CSR;
                end
            end
            OPC_TRAP:   r.num = I_TRAP;
            default:    r.num = I_INVALID;
        endcase
        if (r.num == I_INVALID) r.fmt = FMT_NONE;

        case (r.fmt)
            FMT_R: begin
                r.rs1 = w[19:15]; r.rs2 = w[24:20]; r.rd = w[11:7]; has_rd = 1'b1;
            end
            FMT_I: begin
                r.rs1 = w[19:15]; r.rd = w[11:7]; has_rd = 1'b1;
                r.imm = {{20{w[31]}}, w[31:20]};
            end
            FMT_U: begin
                r.rd = w[11:7]; has_rd = 1'b1;
                r.imm = {w[31:12], 12'b0};
            end
            FMT_S: begin
                r.rs1 = w[19:15]; r.rs2 = w[24:20]; r.rd = w[24:20]; has_rd = 1'b1;
                r.imm = {{20{w[31]}}, w[31:25], w[11:7]};
            end
            FMT_B: begin
                r.rs1 = w[19:15]; r.rs2 = w[24:20];
                r.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            end
            FMT_J: begin
                r.rd = w[11:7]; has_rd = 1'b1;
                r.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            end
            FMT_CSR: begin
                r.rs1 = w[19:15]; r.rd = w[11:7]; has_rd = 1'b1;
                r.csr = w[31:20];
            end
            default: ;
        endcase
        r.discard = has_rd && (r.rd == '0);
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        decode_t want;
        if (i_rst_n) begin
            if (i_start && !i_busy) decode_q.push_back(decode_word(i_instr_word));
            if (i_valid) begin
                if (decode_q.size() == 0) begin
                    $error("result with no request outstanding");
                    fail_count++;
                end else begin
                    want = decode_q.pop_front();
                    check_field("instr_number", want.num, i_instr_number);
                    check_field("operand_format", want.fmt, i_operand_format);
                    check_field("src1_index", want.rs1, i_src1_index);
                    check_field("src2_index", want.rs2, i_src2_index);
                    check_field("dest_index", want.rd, i_dest_index);
                    check_field("immediate", want.imm, i_immediate);
                    check_field("csr_address", want.csr, i_csr_address);
                    check_field("dest_discard", want.discard, i_dest_discard);
                end
            end
        end
        o_pending <= decode_q.size();
    end

endmodule

>>> sim/rv64im_instruction_decoder_unit_tb.sv
// ----------------------------------------------------------------------------
// rv64im_instruction_decoder_unit_tb
// Testbench top for the RV64IM decoder. Issues directed corner-case words,
// then a long run of randomized words with random request gaps and bursts;
// the checker beside the block verifies every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rv64im_instruction_decoder_unit_tb;

    import rvd_pkg::*;
    import rvd_tb_pkg::*;

    localparam int          NUM_RANDOM = 1150;
    localparam logic [6:0]  LEGAL_OPCODES [13] = '{OPC_LUI, OPC_AUIPC, OPC_LOAD, OPC_STORE,
                                                   OPC_IMM, OPC_IMM_W, OPC_REG, OPC_REG_W,
                                                   OPC_JAL, OPC_JALR, OPC_BRANCH,
                                                   OPC_SYSTEM, OPC_TRAP};

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    t_word              i_instr_word = '0;
    logic               busy;
    logic               o_valid;
    t_num               o_instr_number;
    logic [2:0]         o_operand_format;
    t_reg               o_src1_index;
    t_reg               o_src2_index;
    t_reg               o_dest_index;
    logic signed [31:0] o_immediate;
    logic [11:0]        o_csr_address;
    logic               o_dest_discard;
    int                 fail_count;
    int                 pending;

    always #5 i_clk = ~i_clk;

    rv64im_instruction_decoder_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .i_instr_word     (i_instr_word),
        .busy             (busy),
        .o_valid          (o_valid),
        .o_instr_number   (o_instr_number),
        .o_operand_format (o_operand_format),
        .o_src1_index     (o_src1_index),
        .o_src2_index     (o_src2_index),
        .o_dest_index     (o_dest_index),
        .o_immediate      (o_immediate),
        .o_csr_address    (o_csr_address),
        .o_dest_discard   (o_dest_discard)
    );

    rv64im_instruction_decoder_unit_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_instr_word     (i_instr_word),
        .i_valid          (o_valid),
        .i_instr_number   (o_instr_number),
        .i_operand_format (o_operand_format),
        .i_src1_index     (o_src1_index),
        .i_src2_index     (o_src2_index),
        .i_dest_index     (o_dest_index),
        .i_immediate      (o_immediate),
        .i_csr_address    (o_csr_address),
        .i_dest_discard   (o_dest_discard),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    function automatic t_word enc(logic [6:0] f7, t_reg rs2, t_reg rs1, logic [2:0] f3,
                                  t_reg rd, logic [6:0] opc);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    // mostly well-formed words with random fields; some raw noise
    function automatic t_word random_word();
        t_word      w;
        logic [6:0] opc;
        w = $urandom;
        if ($urandom_range(0, 99) < 8) return w;
        opc = LEGAL_OPCODES[4'($urandom_range(0, 12))];
        w[6:0] = opc;
        if (opc == OPC_REG || opc == OPC_REG_W) begin
            case ($urandom_range(0, 3))
                0: w[31:25] = F7_BASE;
                1: w[31:25] = F7_ALT;
                2: w[31:25] = F7_MUL;
                default: ;
            endcase
        end
        if (opc == OPC_SYSTEM) begin
            case ($urandom_range(0, 4))
                0: w = WORD_ECALL;
                1: w = WORD_MRET;
                default: if ($urandom_range(0, 3) != 0) w[14:12] = 3'($urandom_range(1, 3));
            endcase
        end
        if ($urandom_range(0, 7) == 0) w[11:7] = '0;
        if ($urandom_range(0, 7) == 0) w[24:20] = '0;
        return w;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_request(t_word w, bit no_gap);
        int gap;
        start        <= 1'b1;
        i_instr_word <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        gap = no_gap ? 0 : gap_len();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // first edge lets the count catch the last accepted request
    task automatic wait_drained();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int n;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(32'h0000_0000, 1'b0);
        send_request(32'hFFFF_FFFF, 1'b0);
        send_request(WORD_ECALL, 1'b0);
        send_request(WORD_MRET, 1'b0);
        send_request(enc(7'h00, 5'd1, 5'd0, F3_ADD, 5'd0, OPC_SYSTEM), 1'b0);
        send_request(enc(7'h7F, 5'h1F, 5'h1F, F3_SLL, 5'd0, OPC_SYSTEM), 1'b0);
        send_request(enc(7'h00, 5'd0, 5'd2, F3_XOR, 5'd3, OPC_SYSTEM), 1'b0);
        send_request(enc(7'h7F, 5'h1F, 5'h1F, F3_AND, 5'd0, OPC_LUI), 1'b0);
        send_request(enc(7'h00, 5'd0, 5'd0, F3_ADD, 5'h1F, OPC_AUIPC), 1'b0);
        send_request(enc(7'h40, 5'd0, 5'h1F, F3_ADD, 5'd0, OPC_IMM), 1'b0);
        send_request(enc(7'h7F, 5'h1F, 5'd5, F3_SLL, 5'd7, OPC_IMM), 1'b0);
        send_request(enc(7'h3F, 5'h1F, 5'd5, F3_SRL, 5'd7, OPC_IMM), 1'b0);
        send_request(enc(F7_ALT, 5'd3, 5'd4, F3_ADD, 5'd5, OPC_REG), 1'b0);
        send_request(enc(F7_MUL, 5'd3, 5'd4, F3_SLL, 5'd5, OPC_REG), 1'b0);
        send_request(enc(7'h7F, 5'd3, 5'd4, F3_SLT, 5'd5, OPC_REG), 1'b0);
        send_request(enc(F7_ALT, 5'd3, 5'd4, F3_XOR, 5'd5, OPC_REG), 1'b0);
        send_request(enc(7'h7F, 5'd1, 5'd2, F3_SLL, 5'd0, OPC_REG_W), 1'b0);
        send_request(enc(F7_MUL, 5'd1, 5'd2, F3_SLT, 5'd3, OPC_REG_W), 1'b0);
        send_request(enc(F7_MUL, 5'd1, 5'd2, F3_AND, 5'd3, OPC_REG_W), 1'b0);
        send_request(enc(7'h00, 5'd0, 5'd1, F3_AND, 5'd1, OPC_LOAD), 1'b0);
        send_request(enc(7'h7F, 5'd0, 5'd1, F3_SLTU, 5'h1F, OPC_STORE), 1'b0);
        send_request(enc(7'h00, 5'd2, 5'd1, F3_XOR, 5'd0, OPC_STORE), 1'b0);
        send_request(enc(7'h7F, 5'h1F, 5'd1, F3_AND, 5'h1F, OPC_BRANCH), 1'b0);
        send_request(enc(7'h00, 5'd0, 5'd1, F3_SLT, 5'd0, OPC_BRANCH), 1'b0);
        send_request(enc(7'h7F, 5'h1F, 5'h1F, F3_AND, 5'd0, OPC_JAL), 1'b0);
        send_request(enc(7'h5A, 5'd3, 5'd4, F3_AND, 5'd0, OPC_JALR), 1'b0);
        send_request(enc(7'h12, 5'd3, 5'd4, F3_OR, 5'd9, OPC_TRAP), 1'b0);
        send_request(enc(7'h00, 5'd3, 5'd4, F3_ADD, 5'd5, OPC_REG & 7'h7E), 1'b0);

        // hold off until the pipe is empty
        start <= 1'b0;
        wait_drained();

        for (n = 0; n < NUM_RANDOM; n++) begin
            send_request(random_word(), (n % 200) < 40);
            if (n == NUM_RANDOM / 2) begin
                start <= 1'b0;
                wait_drained();
            end
        end

        start <= 1'b0;
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/rvd_pkg.sv
src/rvd_classify.sv
src/rvd_fields.sv
src/rv64im_instruction_decoder_unit.sv
sim/rv64im_instruction_decoder_unit_checker.sv
sim/rv64im_instruction_decoder_unit_tb.sv
